FILE: hdl/shs_pkg.sv
// shs_pkg: constants, types and hash helpers for the string key hash set
// no dependencies; imported by string_key_hash_set
package shs_pkg;

    localparam int BUCKETS     = 1024;
    localparam int WAYS        = 4;
    localparam int MAX_LETTERS = 10;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 50;
    localparam int LEN_W     = 4;
    localparam int LETTER_W  = 5;
    localparam int SLOTS     = KEY_W / LETTER_W;
    localparam int HALF      = (SLOTS + 1) / 2;
    localparam int BUCKET_W  = $clog2(BUCKETS);
    localparam int PROD_W    = BUCKET_W + LETTER_W;
    localparam int ALPHABET  = 26;

    localparam int IN_DATA_W  = ((KEY_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_EXISTS = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LETTERS);

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_HASH  = 4'b0100,
        ST_LOOK  = 4'b1000
    } state_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        return (len > LEN_MAX) ? LEN_MAX : len;
    endfunction

    // clear letters at and above the key length
    function automatic logic [KEY_W-1:0] mask_key(input logic [KEY_W-1:0] key,
                                                  input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] res;
        res = key;
        for (int i = 0; i < SLOTS; i++) begin
            if (i >= int'(len))
                res[i*LETTER_W +: LETTER_W] = '0;
        end
        return res;
    endfunction

    // up to HALF hash steps starting at letter lo
    function automatic logic [BUCKET_W-1:0] hash_part(input logic [BUCKET_W-1:0] x_in,
                                                      input logic [KEY_W-1:0]    key,
                                                      input logic [LEN_W-1:0]    len,
                                                      input int                  lo);
        logic [BUCKET_W-1:0] x;
        logic [PROD_W-1:0]   t;
        logic [LETTER_W-1:0] code;
        x = x_in;
        for (int j = 0; j < HALF; j++) begin
            code = LETTER_W'(key >> (LETTER_W * (lo + j)));
            t = PROD_W'(x) * PROD_W'(ALPHABET) + PROD_W'(code);
            if ((lo + j) < SLOTS && (lo + j) < int'(len))
                x = t[BUCKET_W-1:0];
        end
        return x;
    endfunction

endpackage

FILE: hdl/shs_ram.sv
// shs_ram: generic simple dual-port synchronous ram, registered read
// no dependencies
module shs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

FILE: hdl/string_key_hash_set.sv
// string_key_hash_set: top level of the letter key hash set
// depends on shs_pkg and shs_ram
//
// Each input item inserts, tests or deletes one key of up to ten letters. The
// table holds BUCKETS (1024) rows of WAYS (4) entries in one ram row per
// bucket. An item passes in order through accept with the first half of the
// hash, second half of the hash with the bucket read, then, once the output
// register can take the result, compare of all ways and write-back of the
// row. After reset a clearing pass over all BUCKETS (1024) rows empties the
// ram while s_axis_tready stays low. A result waits in an output register,
// and the next item is accepted while it is held.
module string_key_hash_set (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // key_letters [49:0], key_length [53:50], zero pad
    input  logic [shs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation [1:0]
    input  logic [shs_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // found [0], status [1], zero pad
    output logic [shs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import shs_pkg::*;

    state_t               state_reg, state_next;
    logic [BUCKET_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [BUCKET_W-1:0]  hash_reg, hash_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg, found_next;
    logic                 status_reg, status_next;

    logic                 ram_we, ram_re;
    logic [BUCKET_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]     ram_wdata, ram_rdata;

    row_t                 rd_row, wr_row;
    logic [WAYS-1:0]      hit_first, free_first;
    logic                 hit, have_free, seen_hit, seen_free;
    logic [LEN_W-1:0]     in_len;
    logic [KEY_W-1:0]     in_key;
    logic [BUCKET_W-1:0]  hash_full;
    logic                 look_go;

    shs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (hash_full),
        .rdata (ram_rdata)
    );

    assign in_len    = sat_len(s_axis_tdata[KEY_W +: LEN_W]);
    assign in_key    = mask_key(s_axis_tdata[KEY_W-1:0], in_len);
    assign hash_full = hash_part(hash_reg, key_reg, len_reg, HALF);

    assign rd_row  = row_t'(ram_rdata);
    assign look_go = (state_reg == ST_LOOK) && (!out_valid_reg || m_axis_tready);

    // way compare, first hit and first free way
    always_comb
    begin
        seen_hit  = 1'b0;
        seen_free = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_first[w]  = 1'b0;
            free_first[w] = 1'b0;
            if (rd_row[w].valid)
            begin
                if (!seen_hit && rd_row[w].len == len_reg && rd_row[w].key == key_reg)
                begin
                    hit_first[w] = 1'b1;
                    seen_hit     = 1'b1;
                end
            end
            else if (!seen_free)
            begin
                free_first[w] = 1'b1;
                seen_free     = 1'b1;
            end
        end
        hit       = seen_hit;
        have_free = seen_free;
    end

    always_comb
    begin
        wr_row = rd_row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (op_reg == OP_INSERT && !hit && free_first[w])
            begin
                wr_row[w].valid = 1'b1;
                wr_row[w].len   = len_reg;
                wr_row[w].key   = key_reg;
            end
            if (op_reg == OP_DELETE && hit_first[w])
                wr_row[w] = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = hash_reg;
        ram_wdata      = ROW_W'(wr_row);

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + BUCKET_W'(1);
                if (clr_addr_reg == BUCKET_W'(BUCKETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    key_next   = in_key;
                    len_next   = in_len;
                    hash_next  = hash_part('0, in_key, in_len, 0);
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                ram_re     = 1'b1;
                hash_next  = hash_full;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (look_go)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    found_next     = hit;
                    status_next    = (op_reg == OP_INSERT) && !hit && !have_free;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        len_reg    <= len_next;
        hash_reg   <= hash_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, status_reg, found_reg};

endmodule
